FILE: rtl/ggw_pkg.sv
// ggw_pkg: shared types and constants of the greedy word-wrap block
// no dependencies; imported by the front, queue, back and top level

package ggw_pkg;

  // width of the line-width register and the op width field
  localparam int WIDTH_W = 6;
  // reset line width is capped here even when the store is larger
  localparam int WIDTH_RST_CAP = 60;

  // op queue depth between front and back (power of two)
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // character codes
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;

  // classified input beat
  typedef enum logic [1:0] {
    OP_CHAR  = 2'd0,
    OP_SPACE = 2'd1,
    OP_END   = 2'd2
  } op_kind_t;

  typedef struct packed {
    op_kind_t             kind;
    logic [7:0]           ch;
    logic [WIDTH_W-1:0]   width;
  } ggw_op_t;

endpackage

FILE: rtl/ggw_in_if.sv
// ggw_in_if: input text channel (valid/ready plus one character beat)
// no dependencies

interface ggw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, text_byte, end_of_text, input ready);
  modport sink   (input valid, text_byte, end_of_text, output ready);
endinterface

FILE: rtl/ggw_out_if.sv
// ggw_out_if: output text channel (valid/ready plus one reflowed byte)
// no dependencies

interface ggw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       text_done;

  modport source (output valid, out_byte, run_last, text_done, input ready);
  modport sink   (input valid, out_byte, run_last, text_done, output ready);
endinterface

FILE: rtl/ggw_front.sv
// ggw_front: line-width register and classification of input beats into ops
// depends on ggw_pkg and ggw_in_if

module ggw_front
  import ggw_pkg::*;
#(
  parameter int MAX_WIDTH = 60
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [WIDTH_W-1:0] cfg_wr_data,
  ggw_in_if.sink             in_ch,
  output logic               push_valid,
  input  logic               push_ready,
  output ggw_op_t            push_op
);

  localparam logic [WIDTH_W-1:0] WMAX = WIDTH_W'(MAX_WIDTH);
  localparam logic [WIDTH_W-1:0] WRST =
    WIDTH_W'(MAX_WIDTH < WIDTH_RST_CAP ? MAX_WIDTH : WIDTH_RST_CAP);

  logic [WIDTH_W-1:0] max_width;
  logic [WIDTH_W-1:0] max_width_next;
  logic               is_space;

  // clamp written width into 1..MAX_WIDTH
  always_comb begin
    if (cfg_wr_data == '0) begin
      max_width_next = WIDTH_W'(1);
    end else if (cfg_wr_data > WMAX) begin
      max_width_next = WMAX;
    end else begin
      max_width_next = cfg_wr_data;
    end
  end

  // line width register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_width <= WRST;
    end else if (cfg_wr_en) begin
      max_width <= max_width_next;
    end
  end

  // whitespace: space, tab, lf, vt, ff, cr
  assign is_space = (in_ch.text_byte == CH_SPACE) ||
                    ((in_ch.text_byte >= CH_TAB) && (in_ch.text_byte <= CH_CR));

  // classify beat and hand it to the queue
  always_comb begin
    if (in_ch.end_of_text) begin
      push_op.kind = OP_END;
    end else if (is_space) begin
      push_op.kind = OP_SPACE;
    end else begin
      push_op.kind = OP_CHAR;
    end
    push_op.ch    = in_ch.text_byte;
    push_op.width = max_width;
  end

  assign push_valid  = in_ch.valid;
  assign in_ch.ready = push_ready;

endmodule

FILE: rtl/ggw_queue.sv
// ggw_queue: short op fifo between the classifying front and the output back
// depends on ggw_pkg

module ggw_queue
  import ggw_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push_valid,
  output logic    push_ready,
  input  ggw_op_t push_op,
  output logic    pop_valid,
  input  logic    pop_ready,
  output ggw_op_t pop_op
);

  ggw_op_t           slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != (QPTR_W + 1)'(QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_op     = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // slot storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= QPTR_W'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= QPTR_W'(rd_ptr + 1'b1);
      end
      if (do_push && !do_pop) begin
        count <= (QPTR_W + 1)'(count + 1'b1);
      end else if (do_pop && !do_push) begin
        count <= (QPTR_W + 1)'(count - 1'b1);
      end
    end
  end

endmodule

FILE: rtl/ggw_back.sv
// ggw_back: word store, row state and byte sequencer that drives the output
// depends on ggw_pkg and ggw_out_if

module ggw_back
  import ggw_pkg::*;
#(
  parameter int MAX_WIDTH = 60
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    pop_valid,
  output logic    pop_ready,
  input  ggw_op_t pop_op,
  ggw_out_if.source out_ch
);

  localparam int LEN_W = $clog2(MAX_WIDTH + 1);
  localparam int IDX_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_PRE_CR  = 7'b0000010,
    S_PRE_LF  = 7'b0000100,
    S_ONE     = 7'b0001000,
    S_WORD    = 7'b0010000,
    S_POST_CR = 7'b0100000,
    S_POST_LF = 7'b1000000
  } state_t;

  state_t             state, state_next;
  logic [LEN_W-1:0]   word_len, word_len_next;
  logic [WIDTH_W-1:0] row_len, row_len_next;
  logic               row_has, row_has_next;
  logic               long_mode, long_mode_next;
  logic [WIDTH_W-1:0] word_width, word_width_next;
  logic [IDX_W-1:0]   emit_last, emit_last_next;
  logic [IDX_W-1:0]   word_idx, word_idx_next;
  logic               do_word, do_word_next;
  logic [1:0]         post_cnt, post_cnt_next;
  logic               is_end, is_end_next;
  logic [7:0]         one_byte, one_byte_next;

  logic [7:0]         mem [MAX_WIDTH];
  logic [7:0]         rd_data;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;

  logic               obuf_valid;
  logic [7:0]         obuf_byte;
  logic               obuf_last;
  logic               obuf_done;
  logic               out_free;
  logic               emit;
  logic [7:0]         emit_byte;
  logic               emit_end;
  state_t             after_pre;

  assign out_free  = !obuf_valid || out_ch.ready;
  assign pop_ready = (state == S_IDLE);
  assign wr_addr   = word_len[IDX_W-1:0];

  // where to go once a leading cr lf or single byte is out
  always_comb begin
    if (do_word) begin
      after_pre = S_WORD;
    end else if (post_cnt != 2'd0) begin
      after_pre = S_POST_CR;
    end else begin
      after_pre = S_IDLE;
    end
  end

  // op dispatch and byte sequencing
  always_comb begin
    logic [LEN_W-1:0] new_len;
    logic [7:0]       width_eff;
    logic [7:0]       fit_sum;
    logic             fit;
    logic             pre_crlf;
    logic             pre_one;
    logic             start_word;
    logic [1:0]       post_n;
    logic [7:0]       one_n;

    state_next      = state;
    word_len_next   = word_len;
    row_len_next    = row_len;
    row_has_next    = row_has;
    long_mode_next  = long_mode;
    word_width_next = word_width;
    emit_last_next  = emit_last;
    word_idx_next   = word_idx;
    do_word_next    = do_word;
    post_cnt_next   = post_cnt;
    is_end_next     = is_end;
    one_byte_next   = one_byte;
    wr_en           = 1'b0;
    emit            = 1'b0;
    emit_byte       = CH_LF;
    emit_end        = 1'b0;

    new_len    = LEN_W'(word_len + 1'b1);
    width_eff  = (word_len == '0) ? 8'(pop_op.width) : 8'(word_width);
    fit_sum    = 8'(row_len) + 8'(word_len) + 8'd1;
    fit        = (fit_sum <= 8'(word_width));
    pre_crlf   = 1'b0;
    pre_one    = 1'b0;
    start_word = 1'b0;
    post_n     = 2'd0;
    one_n      = CH_SPACE;

    unique case (state)
      S_IDLE: begin
        if (pop_valid) begin
          word_idx_next = '0;
          unique case (pop_op.kind) inside
            OP_CHAR: begin
              if (long_mode) begin
                // long word streams straight through
                pre_one = 1'b1;
                one_n   = pop_op.ch;
              end else begin
                wr_en = 1'b1;
                if (word_len == '0) begin
                  word_width_next = pop_op.width;
                end
                if (8'(new_len) >= width_eff) begin
                  // word fills a line: flush it on a line of its own
                  pre_crlf       = row_has;
                  start_word     = 1'b1;
                  emit_last_next = word_len[IDX_W-1:0];
                  word_len_next  = '0;
                  row_len_next   = '0;
                  row_has_next   = 1'b0;
                  long_mode_next = 1'b1;
                end else begin
                  word_len_next = new_len;
                end
              end
            end
            OP_SPACE, OP_END: begin
              // close the pending word
              if (long_mode) begin
                post_n         = 2'd1;
                long_mode_next = 1'b0;
              end else if (word_len != '0) begin
                start_word     = 1'b1;
                emit_last_next = IDX_W'(word_len - 1'b1);
                if (row_has && fit) begin
                  pre_one      = 1'b1;
                  row_len_next = WIDTH_W'(fit_sum);
                end else begin
                  pre_crlf     = row_has;
                  row_len_next = WIDTH_W'(word_len);
                end
                row_has_next  = 1'b1;
                word_len_next = '0;
              end
              // end of text adds the final cr lf and clears the row
              if (pop_op.kind == OP_END) begin
                post_n         = 2'(post_n + 1'b1);
                row_len_next   = '0;
                row_has_next   = 1'b0;
                word_len_next  = '0;
                long_mode_next = 1'b0;
              end
            end
            default: begin
            end
          endcase
          do_word_next  = start_word;
          post_cnt_next = post_n;
          one_byte_next = one_n;
          is_end_next   = (pop_op.kind == OP_END);
          if (pre_crlf) begin
            state_next = S_PRE_CR;
          end else if (pre_one) begin
            state_next = S_ONE;
          end else if (start_word) begin
            state_next = S_WORD;
          end else if (post_n != 2'd0) begin
            state_next = S_POST_CR;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_PRE_CR: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_byte  = CH_CR;
          state_next = S_PRE_LF;
        end
      end
      S_PRE_LF, S_ONE: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_byte  = (state == S_ONE) ? one_byte : CH_LF;
          emit_end   = !do_word && (post_cnt == 2'd0);
          state_next = after_pre;
        end
      end
      S_WORD: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_byte = rd_data;
          if (word_idx == emit_last) begin
            emit_end      = (post_cnt == 2'd0);
            word_idx_next = '0;
            state_next    = (post_cnt != 2'd0) ? S_POST_CR : S_IDLE;
          end else begin
            word_idx_next = IDX_W'(word_idx + 1'b1);
          end
        end
      end
      S_POST_CR: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_byte  = CH_CR;
          state_next = S_POST_LF;
        end
      end
      S_POST_LF: begin
        if (out_free) begin
          emit          = 1'b1;
          emit_byte     = CH_LF;
          emit_end      = (post_cnt == 2'd1);
          post_cnt_next = 2'(post_cnt - 1'b1);
          state_next    = (post_cnt == 2'd2) ? S_POST_CR : S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // word store, write-first registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= pop_op.ch;
    end
    if (wr_en && (wr_addr == word_idx_next)) begin
      rd_data <= pop_op.ch;
    end else begin
      rd_data <= mem[word_idx_next];
    end
  end

  // sequencer and row state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      word_len   <= '0;
      row_len    <= '0;
      row_has    <= 1'b0;
      long_mode  <= 1'b0;
      word_width <= WIDTH_W'(1);
      word_idx   <= '0;
      do_word    <= 1'b0;
      post_cnt   <= 2'd0;
      is_end     <= 1'b0;
    end else begin
      state      <= state_next;
      word_len   <= word_len_next;
      row_len    <= row_len_next;
      row_has    <= row_has_next;
      long_mode  <= long_mode_next;
      word_width <= word_width_next;
      word_idx   <= word_idx_next;
      do_word    <= do_word_next;
      post_cnt   <= post_cnt_next;
      is_end     <= is_end_next;
    end
  end

  // op payload held across the byte sequence
  always_ff @(posedge clk) begin
    emit_last <= emit_last_next;
    one_byte  <= one_byte_next;
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      obuf_valid <= 1'b0;
    end else if (emit) begin
      obuf_valid <= 1'b1;
    end else if (out_ch.ready) begin
      obuf_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      obuf_byte <= emit_byte;
      obuf_last <= emit_end;
      obuf_done <= emit_end && is_end;
    end
  end

  assign out_ch.valid     = obuf_valid;
  assign out_ch.out_byte  = obuf_byte;
  assign out_ch.run_last  = obuf_last;
  assign out_ch.text_done = obuf_done;

`ifndef SYNTH
  // a buffered word always stays shorter than its latched width
  a_len_below_width: assert property (@(posedge clk) disable iff (rst)
    !long_mode |-> (8'(word_len) < 8'(word_width)))
    else $error("word length reached latched width outside long word mode");

  // nothing is buffered while a long word streams through
  a_long_empty: assert property (@(posedge clk) disable iff (rst)
    long_mode |-> (word_len == '0))
    else $error("characters buffered during long word mode");

  // the final beat of a text is the last lf of its run
  a_done_is_last_lf: assert property (@(posedge clk) disable iff (rst)
    (obuf_valid && obuf_done) |-> (obuf_last && (obuf_byte == CH_LF)))
    else $error("text end flagged on a beat that is not the closing lf");

  // word readout never runs past the buffered length
  a_word_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_WORD) |-> (do_word && (word_idx <= emit_last)))
    else $error("word readout index beyond buffered word");
`endif

endmodule

FILE: rtl/greedy_word_wrap.sv
// greedy_word_wrap: top level of the greedy word-wrap text reflow block
// depends on ggw_pkg, ggw_in_if, ggw_out_if, ggw_front, ggw_queue, ggw_back
//
//   channel   dir  beat                                  handshake
//   in_ch     in   text_byte[7:0], end_of_text           valid/ready
//   out_ch    out  out_byte[7:0], run_last, text_done    valid/ready
//   cfg       in   cfg_wr_data[5:0] (line width)         cfg_wr_en, no wait
//
// A character that only extends the buffered word is written to the word store.
// An item that produces bytes is dispatched from the idle state, then sends one
// byte per cycle while out_ch takes them, via the word store read port and obuf.
// A 4-deep op queue lets the input keep flowing while the back sends bytes.
// Reset (rst, synchronous) clears control state only; the word store needs none.
// A stalled output holds the back sequencer; the input stalls once the queue fills.

module greedy_word_wrap
  import ggw_pkg::*;
#(
  parameter int MAX_WIDTH = 60
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [WIDTH_W-1:0] cfg_wr_data,
  ggw_in_if.sink             in_ch,
  ggw_out_if.source          out_ch
);

  logic    push_valid;
  logic    push_ready;
  ggw_op_t push_op;
  logic    pop_valid;
  logic    pop_ready;
  ggw_op_t pop_op;

  // classify input beats
  ggw_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_op     (push_op)
  );

  // op queue between front and back
  ggw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_op     (pop_op)
  );

  // word store and byte sequencer
  ggw_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_op    (pop_op),
    .out_ch    (out_ch)
  );

endmodule
